@@ rtl/pnh32_pkg.sv @@
// pnh32_pkg: types, constants and round functions for the path name hash.
// Used by path_name_hash_32. No dependencies.

package pnh32_pkg;

    // Seeds and round constants
    localparam logic [31:0] SEED_LEFT  = 32'h37A8_470E;
    localparam logic [31:0] SEED_RIGHT = 32'h7758_B42B;
    localparam logic [31:0] SEED_KEY   = 32'hF4FA_8928;
    localparam logic [31:0] KEY_XOR    = 32'h267B_0B11;
    localparam logic [31:0] OR_ONE     = 32'h0204_0801;
    localparam logic [31:0] AND_ONE    = 32'hBFEF_7FDF;
    localparam logic [31:0] OR_TWO     = 32'h0080_4021;
    localparam logic [31:0] AND_TWO    = 32'h7DFE_FBFF;
    localparam logic [31:0] TAIL_ONE   = 32'h9BE7_4448;
    localparam logic [31:0] TAIL_TWO   = 32'h66F4_2C48;

    // Byte codes used by normalization
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;
    localparam logic [7:0] CHAR_BSLASH  = 8'h5C;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    // Controller state: plain words, or first tail round done
    typedef enum logic {
        ST_WORD,
        ST_TAIL
    } pnh_state_t;

    // Hash state carried between rounds
    typedef struct packed {
        logic [31:0] acc_left;
        logic [31:0] acc_right;
        logic [31:0] rot_key;
    } pnh_acc_t;

    // Lower-case A-Z and map '/' to backslash, byte by byte
    function automatic logic [31:0] normalize_word(input logic [31:0] w);
        logic [31:0] res;
        logic [7:0]  c;
        res = '0;
        for (int b = 0; b < 4; b++) begin
            c = w[8*b +: 8];
            if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
                c = c + CASE_OFFSET;
            end
            else if (c == CHAR_SLASH) begin
                c = CHAR_BSLASH;
            end
            res[8*b +: 8] = c;
        end
        return res;
    endfunction

    // One mixing round: two parallel 32x32 products, each folded to 32 bits
    function automatic pnh_acc_t mix_round(input pnh_acc_t st, input logic [31:0] w);
        pnh_acc_t    res;
        logic [31:0] key_rot;
        logic [31:0] k;
        logic [31:0] l;
        logic [31:0] r;
        logic [31:0] m1;
        logic [31:0] m2;
        logic [63:0] p1;
        logic [63:0] p2;
        logic [32:0] t1;
        logic [32:0] t2;
        key_rot = {st.rot_key[30:0], st.rot_key[31]};
        k       = key_rot ^ KEY_XOR;
        l       = st.acc_left ^ w;
        r       = st.acc_right ^ w;
        m1      = ((k + r) | OR_ONE) & AND_ONE;
        m2      = ((k + l) | OR_TWO) & AND_TWO;
        p1      = {32'd0, l} * {32'd0, m1};
        p2      = {32'd0, r} * {32'd0, m2};
        // left fold: lo + hi + (hi != 0), then end-around carry
        t1 = {1'b0, p1[31:0]} + {1'b0, p1[63:32]} + {32'd0, (p1[63:32] != 32'd0)};
        // right fold: lo + (hi << 1) + hi[31], carry adds two
        t2 = {1'b0, p2[31:0]} + {1'b0, p2[62:32], 1'b0} + {32'd0, p2[63]};
        res.acc_left  = t1[31:0] + {31'd0, t1[32]};
        res.acc_right = t2[31:0] + (t2[32] ? 32'd2 : 32'd0);
        res.rot_key   = key_rot;
        return res;
    endfunction

endpackage

@@ rtl/path_name_hash_32.sv @@
// path_name_hash_32: streaming 32-bit hash of a path name given as words.
// Depends on pnh32_pkg (constants, normalization and round functions).
//
// Throughput: one nonzero word per cycle; a terminating zero word holds the
//   input register for both tail rounds through the one round unit, and the
//   second waits for room in the output register, which then takes the hash.
// Reset: asynchronous, active low; accumulators and key return to the seeds,
//   word count and all valid flags clear. No clearing pass.

module path_name_hash_32
    import pnh32_pkg::*;
#(
    parameter int MAX_WORDS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] name_word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] hash_value
);

    localparam int CNT_W = $clog2(MAX_WORDS + 1);

    pnh_state_t       state_reg;
    pnh_state_t       state_next;
    pnh_acc_t         acc_reg;
    pnh_acc_t         acc_next;
    pnh_acc_t         round_out;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             in_valid_reg;
    logic             in_zero_reg;
    logic [31:0]      in_word_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [31:0]      out_data_reg;
    logic [31:0]      out_data_next;
    logic [31:0]      round_word;
    logic             out_free;
    logic             in_consume;
    logic             s_beat;

    // Handshake
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || in_consume;
    assign s_beat   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Input register: word is normalized on the way in
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_beat) begin
            in_word_reg <= normalize_word(s_tdata);
            in_zero_reg <= (s_tdata == 32'd0);
        end
    end

    // Round operand: name word, or one of the tail constants
    always_comb
    begin
        if (!in_zero_reg) begin
            round_word = in_word_reg;
        end
        else if (state_reg == ST_WORD) begin
            round_word = TAIL_ONE;
        end
        else begin
            round_word = TAIL_TWO;
        end
    end

    assign round_out = mix_round(acc_reg, round_word);

    // Next state, hash state and result
    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        count_next     = count_reg;
        in_consume     = 1'b0;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        if (in_valid_reg) begin
            if (!in_zero_reg) begin
                // nonzero word: hashed until the word limit is reached
                in_consume = 1'b1;
                if (count_reg < CNT_W'(MAX_WORDS)) begin
                    acc_next   = round_out;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            else begin
                case (state_reg)
                    ST_WORD:
                    begin
                        acc_next   = round_out;
                        state_next = ST_TAIL;
                    end
                    ST_TAIL:
                    begin
                        // second tail round waits for room in the output register
                        if (out_free) begin
                            in_consume     = 1'b1;
                            out_valid_next = 1'b1;
                            out_data_next  = round_out.acc_left ^ round_out.acc_right;
                            acc_next       = '{SEED_LEFT, SEED_RIGHT, SEED_KEY};
                            count_next     = '0;
                            state_next     = ST_WORD;
                        end
                    end
                    default:
                    begin
                        state_next = ST_WORD;
                    end
                endcase
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_WORD;
            acc_reg       <= '{SEED_LEFT, SEED_RIGHT, SEED_KEY};
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

endmodule
